// ----- rtl/kcq_pkg.sv -----
// Package for the keypad chord qualifier.
// Holds field widths, status and register-index codes, state and config structs.
// No dependencies.
package kcq_pkg;

    // Field widths
    localparam int MAP_BITS    = 12;
    localparam int KEY_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = 8;
    localparam int CNT_KEYS_W  = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    // Grid size defaults
    localparam int KEY_ROWS_DEF = 4;
    localparam int KEY_COLS_DEF = 3;

    // Key counts that mean something
    localparam logic [CNT_KEYS_W-1:0] SINGLE_KEY = 4'd1;
    localparam logic [CNT_KEYS_W-1:0] CHORD_KEYS = 4'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DATA  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RESET = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ERASE = 2'd3;

    // Action codes
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CONFIRM = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESET_MASK = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ERASE_MASK = 2'd2;

    // Configuration reset values
    localparam logic [CNT_W-1:0]    CONFIRM_RST    = 8'd3;
    localparam logic [MAP_BITS-1:0] RESET_MASK_RST = 12'd545;
    localparam logic [MAP_BITS-1:0] ERASE_MASK_RST = 12'd2081;

    typedef struct packed {
        logic [CNT_W-1:0]    confirm_count;
        logic [MAP_BITS-1:0] reset_chord_mask;
        logic [MAP_BITS-1:0] erase_chord_mask;
    } cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0]    held_key;
        logic [STATUS_W-1:0] held_status;
        logic                reset_reported;
        logic                erase_reported;
        logic [CNT_W-1:0]    chord_counter;
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] scan_status;
        logic [KEY_W-1:0]    key_position;
    } result_t;

    // Bits of the map that fall inside the key grid
    function automatic logic [MAP_BITS-1:0] grid_mask(input int keys);
        logic [MAP_BITS-1:0] m;
        m = '0;
        for (int b = 0; b < MAP_BITS; b++)
        begin
            m[b] = (b < keys);
        end
        return m;
    endfunction

endpackage

// ----- rtl/keypad_chord_qualifier.sv -----
// Keypad chord qualifier top level: config registers, state, output register.
// Depends on kcq_pkg and kcq_step.
//
//  channel | direction | handshake          | payload
//  s       | in        | s_tvalid/s_tready  | tuser[0] action, tdata[11:0] pressed_map
//  m       | out       | m_tvalid/m_tready  | tuser[1:0] scan_status, tdata[3:0] key_position
//  cfg     | in        | cfg_we             | cfg_addr index, cfg_wdata value
//
// One transaction per cycle unless the output stalls; the result appears in the
// cycle after acceptance. The state update and result are computed in the accept
// cycle by kcq_step and land in the state and output registers at the same edge.
// s_tready is high while the output register is empty or being drained.
// Reset clears state to zero and config to its defaults; no clearing pass.
module keypad_chord_qualifier #(
    parameter int KEY_ROWS = kcq_pkg::KEY_ROWS_DEF,
    parameter int KEY_COLS = kcq_pkg::KEY_COLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kcq_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] pressed_map, rest zero
    input  logic                            s_tuser,   // [0] action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kcq_pkg::M_TDATA_W-1:0]   m_tdata,   // [3:0] key_position, rest zero
    output logic [kcq_pkg::STATUS_W-1:0]    m_tuser,   // [1:0] scan_status
    input  logic                            cfg_we,
    input  logic [kcq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [kcq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    kcq_pkg::cfg_t    cfg_reg;
    kcq_pkg::state_t  state_reg;
    kcq_pkg::state_t  state_next;
    kcq_pkg::result_t result_next;
    kcq_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             s_fire;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_count    <= kcq_pkg::CONFIRM_RST;
            cfg_reg.reset_chord_mask <= kcq_pkg::RESET_MASK_RST;
            cfg_reg.erase_chord_mask <= kcq_pkg::ERASE_MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                kcq_pkg::CFG_CONFIRM:
                    cfg_reg.confirm_count <= cfg_wdata[kcq_pkg::CNT_W-1:0];
                kcq_pkg::CFG_RESET_MASK:
                    cfg_reg.reset_chord_mask <= cfg_wdata[kcq_pkg::MAP_BITS-1:0];
                kcq_pkg::CFG_ERASE_MASK:
                    cfg_reg.erase_chord_mask <= cfg_wdata[kcq_pkg::MAP_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    kcq_step #(
        .KEY_ROWS (KEY_ROWS),
        .KEY_COLS (KEY_COLS)
    ) u_step (
        .action      (s_tuser),
        .pressed_map (s_tdata[kcq_pkg::MAP_BITS-1:0]),
        .cfg         (cfg_reg),
        .state       (state_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    // Held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.scan_status;
    assign m_tdata  = {{(kcq_pkg::M_TDATA_W - kcq_pkg::KEY_W){1'b0}}, out_reg.key_position};

`ifndef SYNTHESIS
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (s_tuser == kcq_pkg::ACT_READ) |=>
            (state_reg.held_status == kcq_pkg::ST_IDLE) && (state_reg.held_key == '0))
        else $error("read did not clear held key and status");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_tvalid)
        else $error("accepted transaction produced no result");

    a_reset_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.held_status == kcq_pkg::ST_RESET) |-> state_reg.reset_reported)
        else $error("reset event held without its reported flag");

    a_erase_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.held_status == kcq_pkg::ST_ERASE) |-> state_reg.erase_reported)
        else $error("erase event held without its reported flag");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.key_position <= kcq_pkg::KEY_W'(kcq_pkg::MAP_BITS)))
        else $error("key position beyond the map");
`endif

endmodule

// ----- rtl/kcq_step.sv -----
// Next-state and result logic for one keypad transaction.
// Pure combinational; depends on kcq_pkg.
module kcq_step #(
    parameter int KEY_ROWS = kcq_pkg::KEY_ROWS_DEF,
    parameter int KEY_COLS = kcq_pkg::KEY_COLS_DEF
) (
    input  logic                          action,
    input  logic [kcq_pkg::MAP_BITS-1:0]  pressed_map,
    input  kcq_pkg::cfg_t                 cfg,
    input  kcq_pkg::state_t               state,
    output kcq_pkg::state_t               state_next,
    output kcq_pkg::result_t              result
);

    localparam logic [kcq_pkg::MAP_BITS-1:0] GRID_MASK =
        kcq_pkg::grid_mask(KEY_ROWS * KEY_COLS);

    logic [kcq_pkg::MAP_BITS-1:0]   keys;
    logic [kcq_pkg::CNT_KEYS_W-1:0] n_keys;
    logic [kcq_pkg::KEY_W-1:0]      first_pos;
    logic                           reset_hit;
    logic                           erase_hit;
    logic [kcq_pkg::CNT_W-1:0]      cnt_inc;
    logic                           reached;

    assign keys = pressed_map & GRID_MASK;

    // Key count
    always_comb
    begin
        n_keys = '0;
        for (int i = 0; i < kcq_pkg::MAP_BITS; i++)
        begin
            n_keys = n_keys + kcq_pkg::CNT_KEYS_W'(keys[i]);
        end
    end

    // Row-major priority: lowest set bit wins, reported as index plus one
    always_comb
    begin
        first_pos = '0;
        for (int i = kcq_pkg::MAP_BITS - 1; i >= 0; i--)
        begin
            if (keys[i])
            begin
                first_pos = kcq_pkg::KEY_W'(i + 1);
            end
        end
    end

    // Chord match against armed chords; reset chord has priority
    assign reset_hit = ((keys & cfg.reset_chord_mask) == cfg.reset_chord_mask)
                       && !state.reset_reported;
    assign erase_hit = ((keys & cfg.erase_chord_mask) == cfg.erase_chord_mask)
                       && !state.erase_reported;
    assign cnt_inc   = state.chord_counter + 1'b1;
    assign reached   = (cnt_inc == cfg.confirm_count);

    always_comb
    begin
        state_next = state;
        if (action == kcq_pkg::ACT_READ)
        begin
            state_next.held_key    = '0;
            state_next.held_status = kcq_pkg::ST_IDLE;
        end
        else if (n_keys == kcq_pkg::SINGLE_KEY)
        begin
            state_next.held_key       = first_pos;
            state_next.held_status    = kcq_pkg::ST_DATA;
            state_next.reset_reported = 1'b0;
            state_next.erase_reported = 1'b0;
            state_next.chord_counter  = '0;
        end
        else if (n_keys == kcq_pkg::CHORD_KEYS)
        begin
            if (reset_hit || erase_hit)
            begin
                state_next.chord_counter = reached ? '0 : cnt_inc;
                if (reached && reset_hit)
                begin
                    state_next.held_status    = kcq_pkg::ST_RESET;
                    state_next.reset_reported = 1'b1;
                end
                else if (reached)
                begin
                    state_next.held_status    = kcq_pkg::ST_ERASE;
                    state_next.erase_reported = 1'b1;
                end
            end
            else
            begin
                state_next.held_status = kcq_pkg::ST_IDLE;
            end
        end
        else
        begin
            state_next.held_status    = kcq_pkg::ST_IDLE;
            state_next.reset_reported = 1'b0;
            state_next.erase_reported = 1'b0;
            state_next.chord_counter  = '0;
        end
    end

    // A read returns the held values before the clear, a scan after the update
    always_comb
    begin
        if (action == kcq_pkg::ACT_READ)
        begin
            result.scan_status  = state.held_status;
            result.key_position = state.held_key;
        end
        else
        begin
            result.scan_status  = state_next.held_status;
            result.key_position = state_next.held_key;
        end
    end

endmodule

// ----- test/tb_keypad_chord_qualifier.sv -----
// Self-checking testbench for keypad_chord_qualifier: directed table, then random traffic.
// Results are compared against an in-bench predictor of the key/chord qualification.
// Depends on kcq_pkg and the keypad_chord_qualifier RTL.
module tb_keypad_chord_qualifier;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_ROWS  = kcq_pkg::KEY_ROWS_DEF;
    localparam int KEY_COLS  = kcq_pkg::KEY_COLS_DEF;
    localparam int GRID_KEYS = KEY_ROWS * KEY_COLS;
    localparam logic [kcq_pkg::MAP_BITS-1:0] GRID_MASK =
        (GRID_KEYS >= kcq_pkg::MAP_BITS) ? '1 : kcq_pkg::MAP_BITS'((1 << GRID_KEYS) - 1);

    localparam int SETTLE_CYCLES    = 3;
    localparam int DRAIN_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT   = 500;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 60;

    // One directed row: input fields plus an optional hand-typed expectation
    typedef struct packed {
        logic                         act;
        logic [kcq_pkg::MAP_BITS-1:0] map;
        logic                         typed;
        logic [kcq_pkg::STATUS_W-1:0] status;
        logic [kcq_pkg::KEY_W-1:0]    key;
    } probe_t;

    // Default chords: reset = keys 0,5,9 (0x221), erase = keys 0,5,11 (0x821)
    localparam probe_t PROBES [0:24] = '{
        '{kcq_pkg::ACT_READ, 12'h000, 1'b1, kcq_pkg::ST_IDLE,  4'd0},  // read right after reset
        '{kcq_pkg::ACT_SCAN, 12'h000, 1'b0, kcq_pkg::ST_IDLE,  4'd0},  // nothing pressed
        '{kcq_pkg::ACT_SCAN, 12'h001, 1'b1, kcq_pkg::ST_DATA,  4'd1},  // first key
        '{kcq_pkg::ACT_SCAN, 12'h800, 1'b1, kcq_pkg::ST_DATA,  4'd12}, // last key
        '{kcq_pkg::ACT_SCAN, 12'hC00, 1'b0, kcq_pkg::ST_IDLE,  4'd0},  // two keys, key kept
        '{kcq_pkg::ACT_READ, 12'h000, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_READ, 12'hFFF, 1'b1, kcq_pkg::ST_IDLE,  4'd0},  // second read, cleared
        '{kcq_pkg::ACT_SCAN, 12'hFFF, 1'b0, kcq_pkg::ST_IDLE,  4'd0},  // every key
        '{kcq_pkg::ACT_SCAN, 12'h221, 1'b0, kcq_pkg::ST_IDLE,  4'd0},  // reset chord, counting
        '{kcq_pkg::ACT_SCAN, 12'h221, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_SCAN, 12'h221, 1'b1, kcq_pkg::ST_RESET, 4'd0},  // confirmed at default
        '{kcq_pkg::ACT_SCAN, 12'h221, 1'b0, kcq_pkg::ST_IDLE,  4'd0},  // already reported
        '{kcq_pkg::ACT_SCAN, 12'h821, 1'b0, kcq_pkg::ST_IDLE,  4'd0},  // erase chord, counting
        '{kcq_pkg::ACT_SCAN, 12'h821, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_SCAN, 12'h007, 1'b0, kcq_pkg::ST_IDLE,  4'd0},  // no chord: counter kept
        '{kcq_pkg::ACT_SCAN, 12'h821, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_READ, 12'h000, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_SCAN, 12'h821, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_SCAN, 12'h030, 1'b0, kcq_pkg::ST_IDLE,  4'd0},  // re-arm
        '{kcq_pkg::ACT_SCAN, 12'h400, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_SCAN, 12'h221, 1'b0, kcq_pkg::ST_IDLE,  4'd0},  // data kept while counting
        '{kcq_pkg::ACT_SCAN, 12'h221, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_SCAN, 12'h221, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_READ, 12'h000, 1'b0, kcq_pkg::ST_IDLE,  4'd0},
        '{kcq_pkg::ACT_SCAN, 12'h010, 1'b0, kcq_pkg::ST_IDLE,  4'd0}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [kcq_pkg::S_TDATA_W-1:0]  s_tdata;    // [11:0] pressed_map, rest zero
    logic                           s_tuser;    // [0] action
    logic                           m_tvalid;
    logic                           m_tready;
    logic [kcq_pkg::M_TDATA_W-1:0]  m_tdata;    // [3:0] key_position, rest zero
    logic [kcq_pkg::STATUS_W-1:0]   m_tuser;    // [1:0] scan_status
    logic                           cfg_we;
    logic [kcq_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [kcq_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // Predictor copy of the block's registers and state
    kcq_pkg::cfg_t    model_cfg;
    kcq_pkg::state_t  model_st;
    kcq_pkg::result_t pending_results[$];

    int  items_sent;
    int  errors;
    bit  src_fast;

    keypad_chord_qualifier #(
        .KEY_ROWS (KEY_ROWS),
        .KEY_COLS (KEY_COLS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Shared chord counter step; true when the confirmation count is hit
    function automatic bit chord_confirmed();
        model_st.chord_counter = model_st.chord_counter + 8'd1;
        if (model_st.chord_counter == model_cfg.confirm_count)
        begin
            model_st.chord_counter = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Predict the result of one transaction and advance the predictor state
    function automatic void qualify_item(input logic act,
                                         input logic [kcq_pkg::MAP_BITS-1:0] map,
                                         output kcq_pkg::result_t res);
        logic [kcq_pkg::MAP_BITS-1:0] keys;
        int                           n;
        keys = map & GRID_MASK;
        n = $countones(keys);
        if (act == kcq_pkg::ACT_READ)
        begin
            res = '{model_st.held_status, model_st.held_key};
            model_st.held_key = '0;
            model_st.held_status = kcq_pkg::ST_IDLE;
        end
        else
        begin
            if (n == kcq_pkg::SINGLE_KEY)
            begin
                // scan downward so the lowest pressed key is the one that sticks
                for (int b = kcq_pkg::MAP_BITS - 1; b >= 0; b--)
                begin
                    if (keys[b])
                        model_st.held_key = kcq_pkg::KEY_W'(b + 1);
                end
                model_st.held_status = kcq_pkg::ST_DATA;
                model_st.reset_reported = 1'b0;
                model_st.erase_reported = 1'b0;
                model_st.chord_counter = '0;
            end
            else if (n == kcq_pkg::CHORD_KEYS)
            begin
                // reset chord has priority; a counted-but-unconfirmed chord leaves status alone
                if ((keys & model_cfg.reset_chord_mask) == model_cfg.reset_chord_mask &&
                    !model_st.reset_reported)
                begin
                    if (chord_confirmed())
                    begin
                        model_st.held_status = kcq_pkg::ST_RESET;
                        model_st.reset_reported = 1'b1;
                    end
                end
                else if ((keys & model_cfg.erase_chord_mask) == model_cfg.erase_chord_mask &&
                         !model_st.erase_reported)
                begin
                    if (chord_confirmed())
                    begin
                        model_st.held_status = kcq_pkg::ST_ERASE;
                        model_st.erase_reported = 1'b1;
                    end
                end
                else
                begin
                    model_st.held_status = kcq_pkg::ST_IDLE;
                end
            end
            else
            begin
                model_st.held_status = kcq_pkg::ST_IDLE;
                model_st.reset_reported = 1'b0;
                model_st.erase_reported = 1'b0;
                model_st.chord_counter = '0;
            end
            res = '{model_st.held_status, model_st.held_key};
        end
    endfunction

    // Map holding every key of a mask, topped up with random keys to three
    function automatic logic [kcq_pkg::MAP_BITS-1:0] chord_map(
        input logic [kcq_pkg::MAP_BITS-1:0] mask);
        logic [kcq_pkg::MAP_BITS-1:0] m;
        m = mask & GRID_MASK;
        while ($countones(m) < kcq_pkg::CHORD_KEYS)
            m[$urandom_range(0, GRID_KEYS - 1)] = 1'b1;
        return m;
    endfunction

    // Offer one transaction after a random gap; record its expectation on acceptance
    task automatic push_item(input logic act, input logic [kcq_pkg::MAP_BITS-1:0] map,
                             input logic typed, input kcq_pkg::result_t typed_res);
        int               gap;
        kcq_pkg::result_t predicted;
        if (items_sent % 32 == 0)
            src_fast = ($urandom_range(0, 3) == 0);
        gap = src_fast ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= kcq_pkg::S_TDATA_W'(map);
        do @(posedge clk); while (!s_tready);
        qualify_item(act, map, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    // Same scan repeated, with an occasional read slipped in
    task automatic hold_scan(input logic [kcq_pkg::MAP_BITS-1:0] map, input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                push_item(kcq_pkg::ACT_READ, kcq_pkg::MAP_BITS'($urandom), 1'b0, '0);
            push_item(kcq_pkg::ACT_SCAN, map, 1'b0, '0);
        end
    endtask

    // Wait for the block to drain, then write all three registers
    task automatic configure(input logic [kcq_pkg::CNT_W-1:0] confirm,
                             input logic [kcq_pkg::MAP_BITS-1:0] rmask,
                             input logic [kcq_pkg::MAP_BITS-1:0] emask);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= kcq_pkg::CFG_CONFIRM;
        cfg_wdata <= kcq_pkg::CFG_DATA_W'(confirm);
        @(posedge clk);
        cfg_addr  <= kcq_pkg::CFG_RESET_MASK;
        cfg_wdata <= rmask;
        @(posedge clk);
        cfg_addr  <= kcq_pkg::CFG_ERASE_MASK;
        cfg_wdata <= emask;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_cfg = '{confirm, rmask, emask};
    endtask

    // Mostly chord holds and single keys, with reads and noisy maps mixed in
    task automatic random_traffic(input int count);
        int                           target;
        int                           pick;
        int                           cap;
        logic [kcq_pkg::MAP_BITS-1:0] map;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                map = chord_map($urandom_range(0, 1) ? model_cfg.reset_chord_mask
                                                     : model_cfg.erase_chord_mask);
                cap = (model_cfg.confirm_count == 0 || model_cfg.confirm_count > 8) ?
                      10 : int'(model_cfg.confirm_count) + 2;
                hold_scan(map, $urandom_range(1, cap));
            end
            else if (pick < 65)
            begin
                map = kcq_pkg::MAP_BITS'(1) << $urandom_range(0, kcq_pkg::MAP_BITS - 1);
                hold_scan(map, $urandom_range(1, 3));
            end
            else if (pick < 80)
            begin
                push_item(kcq_pkg::ACT_READ, kcq_pkg::MAP_BITS'($urandom), 1'b0, '0);
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 2) == 0)
                    map = (kcq_pkg::MAP_BITS'(1) << $urandom_range(0, kcq_pkg::MAP_BITS - 1)) |
                          (kcq_pkg::MAP_BITS'(1) << $urandom_range(0, kcq_pkg::MAP_BITS - 1));
                else
                    map = kcq_pkg::MAP_BITS'($urandom);
                push_item(kcq_pkg::ACT_SCAN, map, 1'b0, '0);
            end
            else
            begin
                push_item(kcq_pkg::ACT_SCAN, chord_map('0), 1'b0, '0);
            end
        end
    endtask

    // Stimulus and end of test
    initial
    begin
        logic [kcq_pkg::MAP_BITS-1:0] mask;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = kcq_pkg::ACT_SCAN;
        cfg_we    = 1'b0;
        cfg_addr  = kcq_pkg::CFG_CONFIRM;
        cfg_wdata = '0;
        items_sent = 0;
        errors     = 0;
        src_fast   = 1'b0;
        model_cfg  = '{kcq_pkg::CONFIRM_RST, kcq_pkg::RESET_MASK_RST, kcq_pkg::ERASE_MASK_RST};
        model_st   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at reset configuration
        foreach (PROBES[i])
            push_item(PROBES[i].act, PROBES[i].map, PROBES[i].typed,
                      kcq_pkg::result_t'{PROBES[i].status, PROBES[i].key});

        // confirm on the first chord scan
        configure(8'd1, chord_map('0), chord_map('0));
        random_traffic(30);

        // largest confirm count; zero reset mask matches any three keys, full erase mask never
        configure(8'd255, '0, '1);
        hold_scan(chord_map('0), 256);
        random_traffic(10);

        // zero count needs a full counter wrap; identical masks hand over reset to erase
        mask = chord_map('0);
        configure(8'd0, mask, mask);
        hold_scan(mask, 260);
        random_traffic(10);

        configure(8'd2, chord_map('0), chord_map('0));
        random_traffic(40);

        // two-key reset chord matches as a subset; four-key erase chord cannot match
        mask = chord_map('0);
        mask[$urandom_range(0, GRID_KEYS - 1)] = 1'b1;
        while ($countones(mask) < 4)
            mask[$urandom_range(0, GRID_KEYS - 1)] = 1'b1;
        configure(kcq_pkg::CNT_W'($urandom_range(3, 6)),
                  (kcq_pkg::MAP_BITS'(1) << $urandom_range(0, 5)) |
                  (kcq_pkg::MAP_BITS'(1) << $urandom_range(6, 11)),
                  mask);
        random_traffic(30);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, one long hold-off, compare against oldest expectation
    initial
    begin
        int               stall;
        int               results_seen;
        bit               sink_fast;
        kcq_pkg::result_t exp_res;
        m_tready = 1'b0;
        results_seen = 0;
        sink_fast = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen % 24 == 0)
                sink_fast = ($urandom_range(0, 3) == 0);
            stall = sink_fast ? 0 : $urandom_range(0, 5);
            if (results_seen == LONG_HOLD_AT)
                stall = LONG_HOLD_CYCLES;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result: expected none, actual status %0d key %0d",
                         $time, m_tuser, m_tdata[kcq_pkg::KEY_W-1:0]);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tuser !== exp_res.scan_status ||
                    m_tdata[kcq_pkg::KEY_W-1:0] !== exp_res.key_position)
                begin
                    errors++;
                    $display({"%0t ns: mismatch: status expected %0d actual %0d, ",
                              "key expected %0d actual %0d"},
                             $time, exp_res.scan_status, m_tuser,
                             exp_res.key_position, m_tdata[kcq_pkg::KEY_W-1:0]);
                end
            end
        end
    end

    // Watchdog: too many cycles without any transaction on either side
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: timeout, %0d results still expected", $time,
                         pending_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
